// ----- hdl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared item types, operation and status codes, and the control structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

  // Operation kinds.
  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;
  localparam logic [2:0] KIND_NEG = 3'd5;
  localparam logic [2:0] KIND_ABS = 3'd6;

  // Result status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DBZ = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // Result modes decided before the reduction.
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_CMP   = 2'd1;
  localparam logic [1:0] MODE_FRAC  = 2'd2;

  // Input item.
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } in_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_less;
    logic               is_equal;
    logic               is_greater;
    logic [1:0]         status;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       prep;
    logic       absval;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early;
    logic gcd_done;
  } stat_t;

endpackage

`default_nettype wire

// ----- hdl/rau_ctrl.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences the products, the binary GCD loop and the two quotient dividers,
// and owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_ABS   = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_GCD   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       ovld_q, ovld_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovld_q;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovld_d  = ovld_q;
    cmd_o   = '0;
    if (ovld_q && out_ready_i) begin
      ovld_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          cnt_d         = '0;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cnt_q[1:0];
        cnt_d         = cnt_q + 6'd1;
        if (cnt_q == 6'd2) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_ABS;
      end
      S_ABS: begin
        cmd_o.absval = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        state_d = stat_i.early ? S_FIN : S_GCD;
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          ovld_d         = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rau_dp.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Shared multiplier, sign and magnitude stage, binary GCD and two restoring
// dividers that reduce numerator and denominator, plus the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rau_dp
  import rau_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire in_t  in_i,
  input  wire cmd_t cmd_i,
  output stat_t     stat_o,
  output out_t      out_o
);

  localparam logic [63:0] Lim = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  in_t                in_q;
  logic signed [63:0] m0_q, m1_q, m2_q;
  logic signed [63:0] p_q, q_q;
  logic [63:0]        mag_q, den_q, u_q, v_q;
  logic [6:0]         k_q;
  logic               neg_q;
  logic [1:0]         mode_q, pst_q;
  logic               lt_q, eq_q, gt_q;
  logic [63:0]        qa_q, qb_q, ra_q, rb_q;
  out_t               out_q;

  logic signed [32:0] mx, my;
  logic signed [65:0] prod;
  logic signed [32:0] an_x, bn_x, ad_x, bd_x;
  logic               is_mul;

  assign an_x   = {in_q.a_num[31], in_q.a_num};
  assign bn_x   = {in_q.b_num[31], in_q.b_num};
  assign ad_x   = {2'b00, in_q.a_den};
  assign bd_x   = {2'b00, in_q.b_den};
  assign is_mul = (in_q.kind == KIND_MUL);

  // Operand selection for the one shared multiplier.
  always_comb begin
    case (cmd_i.mul_sel)
      2'd0: begin
        mx = an_x;
        my = is_mul ? bn_x : bd_x;
      end
      2'd1: begin
        mx = is_mul ? ad_x : bn_x;
        my = is_mul ? bd_x : ad_x;
      end
      default: begin
        mx = ad_x;
        my = bd_x;
      end
    endcase
  end
  assign prod = mx * my;

  // Cross-product combination, or the first operand for negate and absolute value.
  logic signed [63:0] p_d, q_d, an64;
  assign an64 = {{32{in_q.a_num[31]}}, in_q.a_num};
  always_comb begin
    p_d = m0_q;
    q_d = m1_q;
    case (in_q.kind)
      KIND_ADD: begin
        p_d = m0_q + m1_q;
        q_d = m2_q;
      end
      KIND_SUB: begin
        p_d = m0_q - m1_q;
        q_d = m2_q;
      end
      KIND_NEG: begin
        p_d = -an64;
        q_d = {33'd0, in_q.a_den};
      end
      KIND_ABS: begin
        p_d = an64[63] ? -an64 : an64;
        q_d = {33'd0, in_q.a_den};
      end
      default: begin
        p_d = m0_q;
        q_d = m1_q;
      end
    endcase
  end

  // Classification of the item before reduction.
  logic [1:0] mode_d, pst_d;
  logic       den_zero;
  assign den_zero = (in_q.a_den == '0) || (in_q.b_den == '0);
  always_comb begin
    mode_d = MODE_FRAC;
    pst_d  = ST_OK;
    if (in_q.kind <= KIND_CMP && den_zero) begin
      mode_d = MODE_PLAIN;
      pst_d  = ST_DBZ;
    end else if (in_q.kind == KIND_CMP) begin
      mode_d = MODE_CMP;
    end else if (in_q.kind == KIND_DIV && in_q.b_num == '0) begin
      mode_d = MODE_PLAIN;
      pst_d  = ST_DBZ;
    end else if (in_q.kind > KIND_ABS) begin
      mode_d = MODE_PLAIN;
    end else if (q_q == '0) begin
      mode_d = MODE_PLAIN;
      pst_d  = ST_DBZ;
    end else if (p_q == '0) begin
      mode_d = MODE_PLAIN;
    end
  end

  // Restoring divider steps, one quotient bit per lane and cycle.
  logic [64:0] ta, tb;
  logic        ga, gb;
  assign ta = {ra_q, qa_q[63]};
  assign tb = {rb_q, qb_q[63]};
  assign ga = (ta >= {1'b0, v_q});
  assign gb = (tb >= {1'b0, v_q});

  // Result formatting.
  logic [31:0] num_mag;
  out_t        out_d;
  assign num_mag = qa_q[31:0];
  always_comb begin
    out_d         = '0;
    out_d.res_den = 31'd1;
    out_d.status  = ST_OK;
    case (mode_q)
      MODE_PLAIN: begin
        out_d.status = pst_q;
      end
      MODE_CMP: begin
        out_d.is_less    = lt_q;
        out_d.is_equal   = eq_q;
        out_d.is_greater = gt_q;
      end
      MODE_FRAC: begin
        if (qa_q > Lim || qb_q > Lim) begin
          out_d.status = ST_OVF;
        end else begin
          out_d.res_num = neg_q ? -num_mag : num_mag;
          out_d.res_den = qb_q[30:0];
        end
      end
      default: begin
        out_d.status = ST_OK;
      end
    endcase
  end

  assign stat_o.early    = (mode_q != MODE_FRAC);
  assign stat_o.gcd_done = (u_q == v_q);
  assign out_o           = out_q;

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_i;
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        2'd0:    m0_q <= prod[63:0];
        2'd1:    m1_q <= prod[63:0];
        default: m2_q <= prod[63:0];
      endcase
    end
    if (cmd_i.prep) begin
      p_q <= p_d;
      q_q <= q_d;
    end
    if (cmd_i.absval) begin
      neg_q  <= p_q[63] ^ q_q[63];
      mag_q  <= p_q[63] ? -p_q : p_q;
      den_q  <= q_q[63] ? -q_q : q_q;
      u_q    <= p_q[63] ? -p_q : p_q;
      v_q    <= q_q[63] ? -q_q : q_q;
      k_q    <= '0;
      mode_q <= mode_d;
      pst_q  <= pst_d;
      lt_q   <= (m0_q < m1_q);
      eq_q   <= (m0_q == m1_q);
      gt_q   <= (m0_q > m1_q);
    end
    // One binary GCD step: strip common twos, halve a lone even value, else halve the odd difference.
    if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 7'd1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q > v_q) begin
        u_q <= (u_q - v_q) >> 1;
      end else begin
        v_q <= (v_q - u_q) >> 1;
      end
    end
    if (cmd_i.div_init) begin
      qa_q <= mag_q >> k_q;
      qb_q <= den_q >> k_q;
      ra_q <= '0;
      rb_q <= '0;
    end
    if (cmd_i.div_step) begin
      ra_q <= ga ? 64'(ta - {1'b0, v_q}) : ta[63:0];
      rb_q <= gb ? 64'(tb - {1'b0, v_q}) : tb[63:0];
      qa_q <= {qa_q[62:0], ga};
      qb_q <= {qb_q[62:0], gb};
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rational_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact add, subtract, multiply, divide, compare, negate and absolute value
// on reduced fractions, with divide-by-zero and overflow status.
// ----------------------------------------------------------------------------
// One item is worked at a time. Compare, divide-by-zero and zero results skip
// the binary GCD loop and the dividers; a reduced fraction runs the GCD loop
// on the 64-bit magnitudes, then the bit-serial dividers that split out the
// GCD. The GCD loop's length depends on the operands. The result sits in an
// output register, so a new item is taken while the previous result still
// waits.
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic.
  rau_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// ----- bench/rational_arithmetic_unit_top_test.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed and random fraction operations through the valid/ready
// input, predicts each reduced result, and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit_top_test;
  import rau_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam logic [2:0] KIND_NONE = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_item;
  logic out_valid;
  logic out_ready;
  out_t out_item;

  out_t result_queue[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit long_hold;
  bit bursty;
  int unsigned burst_left;

  rational_arithmetic_unit_top #(.VALUE_WIDTH(32)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_item)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Reduces n/d to lowest terms and range-checks it.
  function automatic out_t reduce_fraction(input longint n, input longint unsigned d);
    out_t r;
    logic neg;
    longint unsigned mag;
    longint unsigned x;
    longint unsigned y;
    longint unsigned t;
    r = '0;
    r.res_den = 31'd1;
    neg = n < 0;
    mag = neg ? -n : n;
    if (d == 0) begin
      r.status = ST_DBZ;
      return r;
    end
    if (mag == 0) return r;
    x = mag;
    y = d;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    mag = mag / x;
    d = d / x;
    if (mag > 64'h7FFF_FFFF || d > 64'h7FFF_FFFF) begin
      r.status = ST_OVF;
      return r;
    end
    r.res_num = neg ? 32'(-mag) : 32'(mag);
    r.res_den = d[30:0];
    return r;
  endfunction

  // Computes the expected result of one item.
  function automatic out_t rational_result(input in_t it);
    out_t r;
    longint an;
    longint ad;
    longint bn;
    longint bd;
    longint p;
    longint q;
    r = '0;
    r.res_den = 31'd1;
    an = it.a_num;
    ad = {33'd0, it.a_den};
    bn = it.b_num;
    bd = {33'd0, it.b_den};
    if (it.kind <= KIND_CMP && (ad == 0 || bd == 0)) begin
      r.status = ST_DBZ;
      return r;
    end
    case (it.kind)
      KIND_ADD: r = reduce_fraction(an * bd + bn * ad, ad * bd);
      KIND_SUB: r = reduce_fraction(an * bd - bn * ad, ad * bd);
      KIND_MUL: r = reduce_fraction(an * bn, ad * bd);
      KIND_DIV: begin
        if (bn == 0) begin
          r.status = ST_DBZ;
        end else begin
          p = an * bd;
          q = ad * bn;
          if (q < 0) begin
            p = -p;
            q = -q;
          end
          r = reduce_fraction(p, q);
        end
      end
      KIND_CMP: begin
        p = an * bd;
        q = bn * ad;
        r.is_less = p < q;
        r.is_equal = p == q;
        r.is_greater = p > q;
      end
      KIND_NEG: r = reduce_fraction(-an, ad);
      KIND_ABS: r = reduce_fraction(an < 0 ? -an : an, ad);
      default: ;
    endcase
    return r;
  endfunction

  // Sends one item; valid rises at a falling edge and holds until accepted.
  // Valid stays high after the accept, so the next item follows directly;
  // a gap or wait_results drops it.
  task automatic send_item(input in_t it);
    int unsigned gap;
    gap = 0;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 300) : $urandom_range(0, 3);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    result_queue.push_back(rational_result(it));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every expected result has come back.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (result_queue.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return $urandom_range(0, 2000) - 1000;
      3: return -$urandom_range(1, 32'h7FFF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(1, 12));
      1: return 31'h7FFF_FFFF;
      2: return $urandom_range(0, 40) == 0 ? 31'd0 : 31'($urandom_range(1, 1000));
      default: return 31'($urandom_range(1, 32'h7FFF_FFFF));
    endcase
  endfunction

  function automatic in_t make_item(input logic [2:0] k, input logic [31:0] an,
                                    input logic [30:0] ad, input logic [31:0] bn,
                                    input logic [30:0] bd);
    in_t it;
    it.kind = k;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  // Operand extremes, zero denominators, divide by zero and overflow cases.
  task automatic test_directed();
    send_item(make_item(KIND_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3));
    send_item(make_item(KIND_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2));
    send_item(make_item(KIND_MUL, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1));
    send_item(make_item(KIND_DIV, 32'sd3, 31'd4, 32'sd0, 31'd1));
    send_item(make_item(KIND_DIV, 32'sd3, 31'd4, -32'sd5, 31'd7));
    send_item(make_item(KIND_CMP, 32'sd1, 31'd3, 32'sd2, 31'd6));
    send_item(make_item(KIND_CMP, -32'sd1, 31'd3, 32'sd2, 31'd6));
    send_item(make_item(KIND_CMP, 32'sd1, 31'd0, 32'sd2, 31'd6));
    send_item(make_item(KIND_NEG, 32'h8000_0000, 31'd1, 32'sd0, 31'd0));
    send_item(make_item(KIND_NEG, 32'sd4, 31'd6, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_item(make_item(KIND_ABS, 32'h8000_0000, 31'd2, 32'sd0, 31'd0));
    send_item(make_item(KIND_ABS, -32'sd9, 31'd12, 32'sd0, 31'd0));
    send_item(make_item(KIND_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1));
    send_item(make_item(KIND_ADD, 32'sd1, 31'h7FFF_FFFF, 32'sd1, 31'h7FFF_FFFE));
    send_item(make_item(KIND_SUB, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'd1));
    send_item(make_item(KIND_MUL, 32'sd0, 31'd5, 32'sd7, 31'd0));
    send_item(make_item(KIND_MUL, 32'sd6, 31'd4, 32'sd10, 31'd9));
    send_item(make_item(KIND_DIV, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'd1));
    send_item(make_item(KIND_NONE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'd0));
    send_item(make_item(KIND_ABS, 32'sd0, 31'd0, 32'sd0, 31'd0));
    wait_results();
  endtask

  // Random items; input gaps and receiver stalls follow the bursty flag.
  task automatic test_random(input int unsigned count);
    repeat (count) begin
      send_item(make_item(3'($urandom_range(0, 7)), rand_num(), rand_den(),
                          rand_num(), rand_den()));
    end
  endtask

  // The receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    long_hold = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        long_hold = 1'b0;
      end
      begin
        test_random(12);
        in_valid <= 1'b0;
      end
    join
    wait_results();
  endtask

  // Receiver stall pattern, updated at the falling edge.
  always @(negedge clk) begin
    if (long_hold) begin
      out_ready <= 1'b0;
    end else if (!bursty) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= $urandom_range(0, 9) < 6;
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_item);
        error_count++;
      end else begin
        exp_r = result_queue.pop_front();
        if (out_item.res_num !== exp_r.res_num)
          $display("%0t: res_num expected %0d actual %0d", $realtime,
                   exp_r.res_num, out_item.res_num);
        if (out_item.res_den !== exp_r.res_den)
          $display("%0t: res_den expected %0d actual %0d", $realtime,
                   exp_r.res_den, out_item.res_den);
        if (out_item.is_less !== exp_r.is_less)
          $display("%0t: is_less expected %0b actual %0b", $realtime,
                   exp_r.is_less, out_item.is_less);
        if (out_item.is_equal !== exp_r.is_equal)
          $display("%0t: is_equal expected %0b actual %0b", $realtime,
                   exp_r.is_equal, out_item.is_equal);
        if (out_item.is_greater !== exp_r.is_greater)
          $display("%0t: is_greater expected %0b actual %0b", $realtime,
                   exp_r.is_greater, out_item.is_greater);
        if (out_item.status !== exp_r.status)
          $display("%0t: status expected %0d actual %0d", $realtime,
                   exp_r.status, out_item.status);
        if (out_item !== exp_r) error_count++;
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || long_hold) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    long_hold = 1'b0;
    bursty = 1'b0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    bursty = 1'b1;
    test_backpressure();
    test_random(700);
    // Sender pauses until everything has drained.
    wait_results();
    bursty = 1'b0;
    test_random(300);
    bursty = 1'b1;
    test_random(420);

    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && result_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/rau_pkg.sv
hdl/rau_ctrl.sv
hdl/rau_dp.sv
hdl/rational_arithmetic_unit_top.sv
bench/rational_arithmetic_unit_top_test.sv
